// File: hdl/i2cras_pkg.sv
`default_nettype none

package i2cras_pkg;

    typedef enum logic [2:0] {
        OP_START_READ  = 3'd0,
        OP_START_WRITE = 3'd1,
        OP_TX_READY    = 3'd2,
        OP_RX_BYTE     = 3'd3,
        OP_NACK        = 3'd4
    } opcode_t;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_SEND_REG  = 3'd1,
        MODE_SWITCH_RX = 3'd2,
        MODE_RX_DATA   = 3'd3,
        MODE_TX_DATA   = 3'd4,
        MODE_NACK      = 3'd5
    } mode_t;

    typedef struct packed {
        mode_t      mode;
        logic [6:0] slave_address;
        logic [7:0] register_pointer;
        logic [7:0] rx_remaining;
        logic [7:0] tx_remaining;
        logic [7:0] rx_counter;
    } seq_state_t;

    typedef struct packed {
        logic [2:0] status;
        logic       done_res;
        logic       send_start;
        logic       send_stop;
        logic       direction_transmit;
        logic [6:0] slave_address_out;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_valid;
        logic [7:0] rx_byte_out;
        logic [7:0] rx_position;
    } seq_result_t;

endpackage

`default_nettype wire

// File: hdl/i2c_register_access_sequencer_top.sv
// I2C master register-access sequencer.
// Input channel (s_valid/s_ready) carries one word per bus event or command:
// start read, start write, transmit ready, byte received or nack, with the
// slave address, register address, byte count and data fields beside it.
// Result channel (m_valid/m_ready) returns exactly one word per input word:
// the new mode, done flag, start/stop requests, bus direction, the slave
// address, and a byte to transmit or a received byte with its index.
// The result is registered: it is valid the cycle after the word is
// accepted. Unstalled throughput is one word per cycle; the sequencer
// state and the result word are updated together in a single register stage.
// When the receiver stalls, the result word holds and s_ready drops until
// the result is taken; s_ready follows m_ready in the same cycle, so a
// word taken at the same edge as the pending result keeps the rate at one.
// Reset (aresetn low, synchronous) returns the mode to idle, clears all
// counters and the slave address, and drops m_valid (result fields are not reset).
`default_nettype none

module i2c_register_access_sequencer_top
    import i2cras_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [2:0] s_opcode,
    input  wire logic [6:0] s_device_address,
    input  wire logic [7:0] s_register_address,
    input  wire logic [7:0] s_byte_count,
    input  wire logic [7:0] s_tx_data,
    input  wire logic [7:0] s_rx_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_status,
    output logic            m_done_res,
    output logic            m_send_start,
    output logic            m_send_stop,
    output logic            m_direction_transmit,
    output logic [6:0]      m_slave_address_out,
    output logic            m_tx_valid,
    output logic [7:0]      m_tx_byte,
    output logic            m_rx_valid,
    output logic [7:0]      m_rx_byte_out,
    output logic [7:0]      m_rx_position
);

    seq_state_t  state_reg;
    seq_state_t  state_next;
    seq_result_t res_reg;
    seq_result_t res_next;
    logic        m_valid_reg;
    logic        s_fire;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    i2cras_step u_step (
        .opcode           (s_opcode),
        .device_address   (s_device_address),
        .register_address (s_register_address),
        .byte_count       (s_byte_count),
        .tx_data          (s_tx_data),
        .rx_byte          (s_rx_byte),
        .state            (state_reg),
        .state_next       (state_next),
        .result           (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= '{mode: MODE_IDLE, default: '0};
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                state_reg   <= state_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = res_reg.status;
    assign m_done_res           = res_reg.done_res;
    assign m_send_start         = res_reg.send_start;
    assign m_send_stop          = res_reg.send_stop;
    assign m_direction_transmit = res_reg.direction_transmit;
    assign m_slave_address_out  = res_reg.slave_address_out;
    assign m_tx_valid           = res_reg.tx_valid;
    assign m_tx_byte            = res_reg.tx_byte;
    assign m_rx_valid           = res_reg.rx_valid;
    assign m_rx_byte_out        = res_reg.rx_byte_out;
    assign m_rx_position        = res_reg.rx_position;

    a_tx_rx_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_tx_valid && m_rx_valid))
        else $error("tx and rx bytes in the same word");

    a_rx_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_rx_valid) |-> (m_status == MODE_RX_DATA || m_status == MODE_IDLE))
        else $error("received byte delivered outside a read");

    a_done_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> (m_status == MODE_IDLE || m_status == MODE_NACK))
        else $error("done flagged while a transaction is still running");

    a_start_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_send_start && m_send_stop) |-> (m_status == MODE_RX_DATA))
        else $error("start with stop outside a one-byte read switch");

    a_state_follows_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_fire |=> $stable(state_reg))
        else $error("sequencer state changed without an accepted word");

endmodule

`default_nettype wire

// File: hdl/i2cras_step.sv
`default_nettype none

module i2cras_step
    import i2cras_pkg::*;
(
    input  wire logic [2:0]  opcode,
    input  wire logic [6:0]  device_address,
    input  wire logic [7:0]  register_address,
    input  wire logic [7:0]  byte_count,
    input  wire logic [7:0]  tx_data,
    input  wire logic [7:0]  rx_byte,
    input  wire seq_state_t  state,
    output seq_state_t       state_next,
    output seq_result_t      result
);

    opcode_t    op;
    logic [7:0] rx_left;

    assign op      = opcode_t'(opcode);
    // remaining count once this word is taken in rx data mode
    assign rx_left = (state.rx_remaining != 8'd0) ? state.rx_remaining - 8'd1 : 8'd0;

    // next state
    always_comb begin
        state_next = state;
        case (op)
            OP_START_READ, OP_START_WRITE: begin
                state_next.mode             = MODE_SEND_REG;
                state_next.slave_address    = device_address;
                state_next.register_pointer = register_address;
                state_next.rx_remaining     = (op == OP_START_READ) ? byte_count : 8'd0;
                state_next.tx_remaining     = (op == OP_START_READ) ? 8'd0 : byte_count;
                state_next.rx_counter       = 8'd0;
            end
            OP_TX_READY: begin
                case (state.mode)
                    MODE_SEND_REG: begin
                        state_next.mode = (state.rx_remaining != 8'd0) ? MODE_SWITCH_RX
                                                                       : MODE_TX_DATA;
                    end
                    MODE_SWITCH_RX: begin
                        state_next.mode = MODE_RX_DATA;
                    end
                    MODE_TX_DATA: begin
                        if (state.tx_remaining != 8'd0) begin
                            state_next.tx_remaining = state.tx_remaining - 8'd1;
                        end else begin
                            state_next.mode = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            OP_RX_BYTE: begin
                if (state.mode == MODE_RX_DATA) begin
                    state_next.rx_remaining = rx_left;
                    if (state.rx_remaining != 8'd0) begin
                        state_next.rx_counter = state.rx_counter + 8'd1;
                    end
                    if (rx_left == 8'd0) begin
                        state_next.mode = MODE_IDLE;
                    end
                end
            end
            OP_NACK: begin
                state_next.mode = MODE_NACK;
            end
            default: ;
        endcase
    end

    // result word
    always_comb begin
        result                    = '0;
        result.status             = state_next.mode;
        result.slave_address_out  = state_next.slave_address;
        result.direction_transmit = (state_next.mode == MODE_SEND_REG)
                                 || (state_next.mode == MODE_SWITCH_RX)
                                 || (state_next.mode == MODE_TX_DATA);
        case (op)
            OP_START_READ, OP_START_WRITE: begin
                result.send_start = 1'b1;
            end
            OP_TX_READY: begin
                case (state.mode)
                    MODE_SEND_REG: begin
                        result.tx_valid = 1'b1;
                        result.tx_byte  = state.register_pointer;
                    end
                    MODE_SWITCH_RX: begin
                        result.send_start = 1'b1;
                        result.send_stop  = (state.rx_remaining == 8'd1);
                    end
                    MODE_TX_DATA: begin
                        if (state.tx_remaining != 8'd0) begin
                            result.tx_valid = 1'b1;
                            result.tx_byte  = tx_data;
                        end else begin
                            result.send_stop = 1'b1;
                            result.done_res  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_RX_BYTE: begin
                if (state.mode == MODE_RX_DATA) begin
                    if (state.rx_remaining != 8'd0) begin
                        result.rx_valid    = 1'b1;
                        result.rx_byte_out = rx_byte;
                        result.rx_position = state.rx_counter;
                    end
                    result.send_stop = (rx_left == 8'd1);
                    result.done_res  = (rx_left == 8'd0);
                end
            end
            OP_NACK: begin
                result.done_res = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// File: verif/i2cras_checker.sv
`timescale 1ns / 1ps

module i2cras_checker
    import i2cras_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [6:0] s_device_address,
    input  logic [7:0] s_register_address,
    input  logic [7:0] s_byte_count,
    input  logic [7:0] s_tx_data,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [2:0] m_status,
    input  logic       m_done_res,
    input  logic       m_send_start,
    input  logic       m_send_stop,
    input  logic       m_direction_transmit,
    input  logic [6:0] m_slave_address_out,
    input  logic       m_tx_valid,
    input  logic [7:0] m_tx_byte,
    input  logic       m_rx_valid,
    input  logic [7:0] m_rx_byte_out,
    input  logic [7:0] m_rx_position,
    output int         fail_count,
    output int         checked_count,
    output int         results_owed
);

    // shadow copy of the sequencer state
    mode_t      seq_mode;
    logic [6:0] slave_addr;
    logic [7:0] reg_ptr;
    logic [7:0] rx_left;
    logic [7:0] tx_left;
    logic [7:0] rd_pos;

    seq_result_t bus_actions_due[$];

    initial begin
        fail_count    = 0;
        checked_count = 0;
        results_owed  = 0;
    end

    task automatic check_field(input string fname, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_count++;
        end
    endtask

    // one bus event or command through the sequencer, giving the bus actions it causes
    task automatic sequence_bus_event(input logic [2:0] op, input logic [6:0] dev,
                                      input logic [7:0] first_reg, input logic [7:0] count,
                                      input logic [7:0] txd, input logic [7:0] rxd,
                                      output seq_result_t r);
        r = '0;
        case (op)
            OP_START_READ, OP_START_WRITE: begin
                // a start aborts whatever was running
                seq_mode   = MODE_SEND_REG;
                slave_addr = dev;
                reg_ptr    = first_reg;
                rx_left    = (op == OP_START_READ) ? count : 8'd0;
                tx_left    = (op == OP_START_READ) ? 8'd0 : count;
                rd_pos     = 8'd0;
                r.send_start = 1'b1;
            end
            OP_TX_READY: begin
                case (seq_mode)
                    MODE_SEND_REG: begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = reg_ptr;
                        seq_mode   = (rx_left != 8'd0) ? MODE_SWITCH_RX : MODE_TX_DATA;
                    end
                    MODE_SWITCH_RX: begin
                        seq_mode     = MODE_RX_DATA;
                        r.send_start = 1'b1;
                        if (rx_left == 8'd1) r.send_stop = 1'b1;
                    end
                    MODE_TX_DATA: begin
                        if (tx_left != 8'd0) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = txd;
                            tx_left    = tx_left - 8'd1;
                        end else begin
                            r.send_stop = 1'b1;
                            r.done_res  = 1'b1;
                            seq_mode    = MODE_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            OP_RX_BYTE: begin
                if (seq_mode == MODE_RX_DATA) begin
                    if (rx_left != 8'd0) begin
                        r.rx_valid    = 1'b1;
                        r.rx_byte_out = rxd;
                        r.rx_position = rd_pos;
                        rd_pos        = rd_pos + 8'd1;
                        rx_left       = rx_left - 8'd1;
                    end
                    // stop goes out while the last byte is still on its way
                    if (rx_left == 8'd1) begin
                        r.send_stop = 1'b1;
                    end else if (rx_left == 8'd0) begin
                        seq_mode   = MODE_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
            OP_NACK: begin
                seq_mode   = MODE_NACK;
                r.done_res = 1'b1;
            end
            default: ;
        endcase
        r.status             = seq_mode;
        r.direction_transmit = (seq_mode == MODE_SEND_REG) || (seq_mode == MODE_SWITCH_RX) ||
                               (seq_mode == MODE_TX_DATA);
        r.slave_address_out  = slave_addr;
    endtask

    always @(posedge aclk) begin : monitor
        seq_result_t want;
        seq_result_t fresh;
        if (!aresetn) begin
            seq_mode   = MODE_IDLE;
            slave_addr = '0;
            reg_ptr    = '0;
            rx_left    = '0;
            tx_left    = '0;
            rd_pos     = '0;
            bus_actions_due.delete();
        end else begin
            // the result leaving now always belongs to an earlier word
            if (m_valid && m_ready) begin
                if (bus_actions_due.size() == 0) begin
                    $error("result word with nothing outstanding");
                    fail_count++;
                end else begin
                    want = bus_actions_due.pop_front();
                    check_field("status", 8'(want.status), 8'(m_status));
                    check_field("done_res", 8'(want.done_res), 8'(m_done_res));
                    check_field("send_start", 8'(want.send_start), 8'(m_send_start));
                    check_field("send_stop", 8'(want.send_stop), 8'(m_send_stop));
                    check_field("direction_transmit", 8'(want.direction_transmit),
                                8'(m_direction_transmit));
                    check_field("slave_address_out", 8'(want.slave_address_out),
                                8'(m_slave_address_out));
                    check_field("tx_valid", 8'(want.tx_valid), 8'(m_tx_valid));
                    check_field("tx_byte", want.tx_byte, m_tx_byte);
                    check_field("rx_valid", 8'(want.rx_valid), 8'(m_rx_valid));
                    check_field("rx_byte_out", want.rx_byte_out, m_rx_byte_out);
                    check_field("rx_position", want.rx_position, m_rx_position);
                    checked_count++;
                end
            end
            if (s_valid && s_ready) begin
                sequence_bus_event(s_opcode, s_device_address, s_register_address,
                                   s_byte_count, s_tx_data, s_rx_byte, fresh);
                bus_actions_due.push_back(fresh);
            end
        end
        results_owed = bus_actions_due.size();
    end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import i2cras_pkg::*;

    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;
    localparam int WORDS_PER_PHASE = 150;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [2:0] s_opcode = '0;
    logic [6:0] s_device_address = '0;
    logic [7:0] s_register_address = '0;
    logic [7:0] s_byte_count = '0;
    logic [7:0] s_tx_data = '0;
    logic [7:0] s_rx_byte = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_status;
    logic       m_done_res;
    logic       m_send_start;
    logic       m_send_stop;
    logic       m_direction_transmit;
    logic [6:0] m_slave_address_out;
    logic       m_tx_valid;
    logic [7:0] m_tx_byte;
    logic       m_rx_valid;
    logic [7:0] m_rx_byte_out;
    logic [7:0] m_rx_position;

    int fail_count;
    int checked_count;
    int results_owed;

    int idle_pct = 0;
    int stall_pct = 0;
    int words_sent = 0;
    int seq_words = 0;
    int transactions = 0;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    i2c_register_access_sequencer_top u_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_opcode             (s_opcode),
        .s_device_address     (s_device_address),
        .s_register_address   (s_register_address),
        .s_byte_count         (s_byte_count),
        .s_tx_data            (s_tx_data),
        .s_rx_byte            (s_rx_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_done_res           (m_done_res),
        .m_send_start         (m_send_start),
        .m_send_stop          (m_send_stop),
        .m_direction_transmit (m_direction_transmit),
        .m_slave_address_out  (m_slave_address_out),
        .m_tx_valid           (m_tx_valid),
        .m_tx_byte            (m_tx_byte),
        .m_rx_valid           (m_rx_valid),
        .m_rx_byte_out        (m_rx_byte_out),
        .m_rx_position        (m_rx_position)
    );

    i2cras_checker u_checker (.*);

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // called right after a falling edge, returns right after one
    task automatic send_word(input logic [2:0] op, input logic [6:0] dev,
                             input logic [7:0] first_reg, input logic [7:0] count,
                             input logic [7:0] txd, input logic [7:0] rxd);
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_opcode           = op;
        s_device_address   = dev;
        s_register_address = first_reg;
        s_byte_count       = count;
        s_tx_data          = txd;
        s_rx_byte          = rxd;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    task automatic send_event(input logic [2:0] op, input logic [7:0] count);
        send_word(op, 7'($urandom), 8'($urandom), count, 8'($urandom), 8'($urandom));
    endtask

    // one word of a well-formed sequence, now and then preceded by a stray word
    task automatic sequence_word(input logic [2:0] op);
        if ($urandom_range(99) < 4) begin
            send_event(3'($urandom), 8'($urandom));
        end
        send_event(op, 8'($urandom));
        seq_words++;
    endtask

    task automatic run_transaction();
        logic       is_read;
        logic [7:0] count;
        is_read = 1'($urandom_range(1));
        // mostly short transfers, a few long ones
        count = ($urandom_range(99) < 3) ? 8'($urandom_range(255)) : 8'($urandom_range(5));
        send_event(is_read ? OP_START_READ : OP_START_WRITE, count);
        seq_words++;
        transactions++;
        sequence_word(OP_TX_READY);
        if (is_read && count != 8'd0) begin
            sequence_word(OP_TX_READY);
            repeat (count) sequence_word(OP_RX_BYTE);
        end else begin
            repeat (count) sequence_word(OP_TX_READY);
            sequence_word(OP_TX_READY);
        end
    endtask

    task automatic wait_drained();
        s_valid = 1'b0;
        while (results_owed != 0) @(negedge aclk);
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // events that mean nothing while idle
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'hff, 8'h00);
        send_word(OP_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'hff);
        send_word(OP_UNUSED_LO, 7'h7f, 8'hff, 8'hff, 8'hff, 8'hff);
        send_word(OP_UNUSED_HI, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // two-byte write at the top of the address ranges
        send_word(OP_START_WRITE, 7'h7f, 8'hff, 8'h02, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'hff, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // one-byte read: repeated start and stop together
        send_word(OP_START_READ, 7'h00, 8'h00, 8'h01, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'hff);
        send_word(OP_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'h5a);
        // zero-byte read behaves like a zero-byte write
        send_word(OP_START_READ, 7'h55, 8'haa, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        // read cut short by a new start, then a nack mid-write
        send_word(OP_START_READ, 7'h2a, 8'h10, 8'h03, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'h01);
        send_word(OP_START_WRITE, 7'h15, 8'h20, 8'hff, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'ha5, 8'h00);
        send_word(OP_NACK, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_TX_READY, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        send_word(OP_RX_BYTE, 7'h00, 8'h00, 8'h00, 8'h00, 8'h33);
        send_word(OP_NACK, 7'h7f, 8'hff, 8'hff, 8'hff, 8'hff);

        // hold off until everything directed has come back
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 85; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 85; end
                default: begin idle_pct = 17; stall_pct = 17; end
            endcase
            while (seq_words < (p + 1) * WORDS_PER_PHASE) run_transaction();
            wait_drained();
        end

        stall_pct = 0;
        repeat (4) @(negedge aclk);
        $display("run: %0d words sent, %0d transactions over four idle/stall mixes",
                 words_sent, transactions);
        $display("run: %0d result words compared field by field", checked_count);
        if (fail_count == 0 && results_owed == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
